// ===== src/rrss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared types and constants of the round-robin sleep scheduler.
// ----------------------------------------------------------------------------
package rrss_pkg;

  localparam int unsigned ID_W          = 3;
  localparam int unsigned OPC_W         = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned TICK_IN_W     = 32;

  localparam int unsigned MAX_TASKS_DEF  = 8;
  localparam int unsigned TICK_WIDTH_DEF = 32;

  typedef enum logic [OPC_W-1:0] {
    OP_CREATE   = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_DELAY    = 2'd2,
    OP_TICK     = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NO_CURRENT = 2'd2
  } status_e;

  // One result transaction
  typedef struct packed {
    logic [ID_W-1:0] current_task;
    logic            has_current;
    logic            woken_flag;
    status_e         status;
  } res_t;

endpackage

// ===== src/rrss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rrss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_ctrl
// Sequencer: ready queue and sleep list kept in RAM, read-modify-write.
// ----------------------------------------------------------------------------
module rrss_ctrl #(
  parameter int unsigned MaxTasks  = rrss_pkg::MAX_TASKS_DEF,
  parameter int unsigned TickWidth = rrss_pkg::TICK_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rrss_pkg::OPC_W-1:0]    opcode_i,
  input  logic [rrss_pkg::ID_W-1:0]     task_id_i,
  input  logic [rrss_pkg::TICK_IN_W-1:0] tick_now_i,
  input  logic [rrss_pkg::TICK_IN_W-1:0] delay_ms_i,
  output logic                          res_valid_o,
  output rrss_pkg::res_t                res_o,
  input  logic                          res_stall_i
);

  import rrss_pkg::*;

  localparam int unsigned IDX_W = $clog2(MaxTasks);
  localparam int unsigned CNT_W = $clog2(MaxTasks + 1);
  localparam int unsigned SLP_W = ID_W + TickWidth;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCH_WR,
    S_DLY_WR,
    S_TICK,
    S_FIN,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  rc_q, rc_d;
  logic [CNT_W-1:0]  sc_q, sc_d;
  logic              rv_q, rv_d;
  logic              woken_q, woken_d;
  status_e           status_q, status_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  kept_q, kept_d;
  logic              pend_q, pend_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  // captured transaction
  opcode_e           op_q;
  logic [ID_W-1:0]   id_q;
  logic [TickWidth-1:0] tick_q;
  logic [TickWidth-1:0] ms_q;

  // RAM ports
  logic              rdy_we, rdy_re;
  logic [IDX_W-1:0]  rdy_waddr, rdy_raddr;
  logic [ID_W-1:0]   rdy_wdata, rdy_rdata;
  logic              slp_we, slp_re;
  logic [IDX_W-1:0]  slp_waddr, slp_raddr;
  logic [SLP_W-1:0]  slp_wdata, slp_rdata;

  logic [CNT_W:0]    tail_sum;
  logic [IDX_W-1:0]  tail_pos;
  logic [IDX_W-1:0]  head_inc;
  logic [CNT_W:0]    total;
  logic              accept;
  logic              due;

  rrss_ram #(.Width(ID_W), .Depth(MaxTasks)) u_ready_ram (
    .clk_i   (clk_i),
    .we_i    (rdy_we),
    .waddr_i (rdy_waddr),
    .wdata_i (rdy_wdata),
    .re_i    (rdy_re),
    .raddr_i (rdy_raddr),
    .rdata_o (rdy_rdata)
  );

  rrss_ram #(.Width(SLP_W), .Depth(MaxTasks)) u_sleep_ram (
    .clk_i   (clk_i),
    .we_i    (slp_we),
    .waddr_i (slp_waddr),
    .wdata_i (slp_wdata),
    .re_i    (slp_re),
    .raddr_i (slp_raddr),
    .rdata_o (slp_rdata)
  );

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // tail slot = (head + count) mod MaxTasks
  always_comb begin
    tail_sum = {1'b0, CNT_W'(head_q)} + {1'b0, rc_q};
    if (tail_sum >= (CNT_W + 1)'(MaxTasks)) begin
      tail_sum = tail_sum - (CNT_W + 1)'(MaxTasks);
    end
    tail_pos = tail_sum[IDX_W-1:0];
  end

  assign head_inc = (head_q == IDX_W'(MaxTasks - 1)) ? '0 : head_q + 1'b1;
  assign total    = {1'b0, rc_q} + {1'b0, sc_q};
  assign due      = (tick_q >= slp_rdata[TickWidth-1:0]);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    rc_d        = rc_q;
    sc_d        = sc_q;
    rv_d        = rv_q;
    woken_d     = woken_q;
    status_d    = status_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    pend_d      = pend_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rdy_we      = 1'b0;
    rdy_waddr   = tail_pos;
    rdy_wdata   = id_q;
    rdy_re      = 1'b0;
    rdy_raddr   = head_q;
    slp_we      = 1'b0;
    slp_waddr   = sc_q[IDX_W-1:0];
    slp_wdata   = {rdy_rdata, TickWidth'(tick_q + ms_q)};
    slp_re      = 1'b0;
    slp_raddr   = idx_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          state_d  = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (op_q)
          OP_CREATE: begin
            if (total >= (CNT_W + 1)'(MaxTasks)) begin
              status_d = ST_FULL;
            end else begin
              rdy_we = 1'b1;
              rc_d   = rc_q + 1'b1;
            end
            state_d = S_FIN;
          end
          OP_SCHEDULE: begin
            if (rv_q && (rc_q != '0)) begin
              rdy_re  = 1'b1;
              state_d = S_SCH_WR;
            end else begin
              // nothing to rotate: pick the head if there is one
              rv_d = (rc_q != '0);
              if (rc_q != '0) begin
                woken_d = 1'b0;
              end
              state_d = S_FIN;
            end
          end
          OP_DELAY: begin
            if (!rv_q || (rc_q == '0) || (sc_q >= CNT_W'(MaxTasks))) begin
              status_d = ST_NO_CURRENT;
              state_d  = S_FIN;
            end else begin
              rdy_re  = 1'b1;
              state_d = S_DLY_WR;
            end
          end
          OP_TICK: begin
            idx_d   = '0;
            kept_d  = '0;
            pend_d  = 1'b0;
            state_d = S_TICK;
          end
        endcase
      end

      S_SCH_WR: begin
        // old head goes to the tail; slot head+count equals new head+count-1
        rdy_we    = 1'b1;
        rdy_wdata = rdy_rdata;
        head_d    = head_inc;
        rv_d      = 1'b1;
        woken_d   = 1'b0;
        state_d   = S_FIN;
      end

      S_DLY_WR: begin
        slp_we = 1'b1;
        sc_d   = sc_q + 1'b1;
        head_d = head_inc;
        rc_d   = rc_q - 1'b1;
        rv_d   = (rc_q > CNT_W'(1));
        if (rc_q > CNT_W'(1)) begin
          woken_d = 1'b0;
        end
        state_d = S_FIN;
      end

      S_TICK: begin
        // entry read last cycle is handled while the next one is fetched
        if (pend_q) begin
          if (due) begin
            rdy_we    = 1'b1;
            rdy_wdata = slp_rdata[TickWidth +: ID_W];
            rc_d      = rc_q + 1'b1;
            woken_d   = 1'b1;
          end else begin
            slp_we    = 1'b1;
            slp_waddr = kept_q[IDX_W-1:0];
            slp_wdata = slp_rdata;
            kept_d    = kept_q + 1'b1;
          end
        end
        if (idx_q < sc_q) begin
          slp_re = 1'b1;
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d  = 1'b0;
          sc_d    = kept_d;
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        rdy_re  = 1'b1;
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!res_stall_i) begin
          res_valid_d        = 1'b1;
          res_d.has_current  = rv_q && (rc_q != '0);
          res_d.current_task = (rv_q && (rc_q != '0)) ? rdy_rdata : '0;
          res_d.woken_flag   = woken_q;
          res_d.status       = status_q;
          state_d            = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      rc_q        <= '0;
      sc_q        <= '0;
      rv_q        <= 1'b0;
      woken_q     <= 1'b0;
      status_q    <= ST_OK;
      idx_q       <= '0;
      kept_q      <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      rc_q        <= rc_d;
      sc_q        <= sc_d;
      rv_q        <= rv_d;
      woken_q     <= woken_d;
      status_q    <= status_d;
      idx_q       <= idx_d;
      kept_q      <= kept_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_e'(opcode_i);
      id_q   <= task_id_i;
      tick_q <= TickWidth'(tick_now_i);
      ms_q   <= TickWidth'(delay_ms_i);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/rrss_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrss_out
// Output register of the result channel.
// ----------------------------------------------------------------------------
module rrss_out (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           res_valid_i,
  input  rrss_pkg::res_t                 res_i,
  output logic                           res_stall_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rrss_pkg::ID_W-1:0]      current_task_o,
  output logic                           has_current_o,
  output logic                           woken_flag_o,
  output logic [rrss_pkg::STATUS_W-1:0]  status_o
);

  import rrss_pkg::*;

  logic valid_q;
  res_t data_q;

  // full and not drained this cycle
  assign res_stall_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!res_stall_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!res_stall_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign current_task_o = data_q.current_task;
  assign has_current_o  = data_q.has_current;
  assign woken_flag_o   = data_q.woken_flag;
  assign status_o       = data_q.status;

endmodule

// ===== src/round_robin_sleep_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_sleep_scheduler
// Round-robin ready queue with a timed sleep list, one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command transaction:
//   opcode create, schedule, delay or tick, with task id, tick and delay.
//   Output channel (out_valid_o / out_stall_i) returns one result per
//   command: running task, has-current flag, woken flag and status.
// Sequencing / throughput:
//   Every command passes the exec, finish and output states; a schedule
//   that rotates and an accepted delay add a RAM write state, and a tick
//   walks the sleep list (one sleep RAM entry is fetched per cycle and
//   compacted in place). A new command is accepted only once the previous
//   result has been loaded, so commands do not overlap. The sequencer and
//   the single-read ready and sleep RAMs set this sequence.
// Reset:
//   Asynchronous, active low. Queue and sleep counts, head pointer, running
//   and woken flags clear; RAM contents are left as they are.
// Back-pressure:
//   The result sits in an output register; the next command runs while it
//   waits, and only its final load stalls until the register drains.
// ----------------------------------------------------------------------------
module round_robin_sleep_scheduler #(
  parameter int unsigned MaxTasks  = rrss_pkg::MAX_TASKS_DEF,
  parameter int unsigned TickWidth = rrss_pkg::TICK_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rrss_pkg::OPC_W-1:0]     opcode_i,
  input  logic [rrss_pkg::ID_W-1:0]      task_id_i,
  input  logic [rrss_pkg::TICK_IN_W-1:0] tick_now_i,
  input  logic [rrss_pkg::TICK_IN_W-1:0] delay_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rrss_pkg::ID_W-1:0]      current_task_o,
  output logic                           has_current_o,
  output logic                           woken_flag_o,
  output logic [rrss_pkg::STATUS_W-1:0]  status_o
);

  import rrss_pkg::*;

  // result handoff from sequencer to output register
  logic res_valid;
  res_t res;
  logic res_stall;

  // Sequencer with the ready-queue RAM and the sleep-list RAM
  rrss_ctrl #(
    .MaxTasks  (MaxTasks),
    .TickWidth (TickWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .task_id_i   (task_id_i),
    .tick_now_i  (tick_now_i),
    .delay_ms_i  (delay_ms_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_stall_i (res_stall)
  );

  // Output register decouples the receiver's stall from the sequencer
  rrss_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_valid_i    (res_valid),
    .res_i          (res),
    .res_stall_o    (res_stall),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .current_task_o (current_task_o),
    .has_current_o  (has_current_o),
    .woken_flag_o   (woken_flag_o),
    .status_o       (status_o)
  );

endmodule
